// ===== sv/pli_pkg.sv =====
package pli_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] bp_value;
		logic signed [DATA_W-1:0] bp_time;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== sv/pli_cell.sv =====
module pli_cell (
	input  logic            clk,
	input  logic            shift,
	input  pli_pkg::entry_t din,
	output pli_pkg::entry_t dout
);

	pli_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

// ===== sv/pli_div.sv =====
module pli_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pli_pkg::PROD_W-1:0]   dividend,
	input  logic [pli_pkg::DATA_W-1:0]   divisor,
	output logic                         done,
	output logic [pli_pkg::DATA_W-1:0]   quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [pli_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [pli_pkg::PROD_W-1:0]      work_q;
	logic [pli_pkg::DATA_W-1:0]      rem_q;
	logic [pli_pkg::DATA_W-1:0]      divisor_q;
	logic [pli_pkg::DATA_W:0]        rem_shift;
	logic [pli_pkg::DATA_W+1:0]      diff;
	logic                            ge;

	assign rem_shift = {rem_q, work_q[pli_pkg::PROD_W-1]};
	assign diff = {1'b0, rem_shift} - {2'b00, divisor_q};
	assign ge = !diff[pli_pkg::DATA_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				done_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[pli_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? diff[pli_pkg::DATA_W-1:0] : rem_shift[pli_pkg::DATA_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = work_q[pli_pkg::DATA_W-1:0];

endmodule

// ===== sv/piecewise_linear_interpolator.sv =====
// Breakpoint table with linear interpolation, all values signed Q16.16. The user field selects
// the operation: clear, append a breakpoint, or query. Clear and append are handled in the
// idle state, so the input stays ready; an append to a full table is dropped. The breakpoints
// live in a ring of cells, and a query rotates the whole ring once, comparing the query time
// against each stored interval as it passes the head of the ring. A clamped result, a miss or
// one from an interval of zero or negative width then goes straight from the decide state to
// the done state and the output register; an interpolated one passes through the multiply
// state and a 64-step restoring divider first. A query on an empty table skips the rotation
// and goes from idle straight to the done state. Only queries produce output words; the input
// is accepted again as soon as the query result has been placed in the output register.
module piecewise_linear_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // time_in [31:0], value_in [63:32]
	input  logic [1:0]  s_tuser,   // opcode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value_out [31:0]
	output logic [0:0]  m_tuser    // table_empty [0]
);

	localparam int D = pli_pkg::TABLE_DEPTH;
	localparam int W = pli_pkg::DATA_W;

	pli_pkg::state_t state_q, state_d;

	logic                        in_acc;
	logic                        out_free;
	logic                        scan_en;
	logic                        div_start;
	logic                        shift_en;
	logic                        append_en;

	logic [pli_pkg::CNT_W-1:0]   count_q;
	logic [pli_pkg::IDX_W-1:0]   k_q;
	logic [pli_pkg::IDX_W-1:0]   start_q;
	logic signed [W-1:0]         qt_q;

	pli_pkg::entry_t             cell_out [D];
	pli_pkg::entry_t             tail_in;
	pli_pkg::entry_t             cur;
	pli_pkg::entry_t             prev_q;
	pli_pkg::entry_t             new_entry;

	logic                        first_le_q;
	logic                        last_ge_q;
	logic                        found_q;
	logic signed [W-1:0]         v_first_q;
	logic signed [W-1:0]         v_last_q;
	logic signed [W-1:0]         it0_q, it1_q, iv0_q, iv1_q;

	logic signed [W:0]           width_c, dv_c, dt_c;
	logic                        width_bad;
	logic [W-1:0]                mag_c;
	logic [W-1:0]                mag_q, dt_q, width_q;
	logic                        neg_q;

	logic                        div_done;
	logic [W-1:0]                quo;
	logic [pli_pkg::PROD_W-1:0]  prod;

	logic signed [W-1:0]         res_q;
	logic                        empty_q;
	logic                        m_tvalid_q;
	logic [W-1:0]                m_tdata_q;
	logic                        m_tuser_q;

	assign in_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign append_en = in_acc && (s_tuser == pli_pkg::OP_APPEND)
		&& (count_q != pli_pkg::CNT_W'(D));
	assign shift_en = scan_en || append_en;

	assign new_entry.bp_time = s_tdata[W-1:0];
	assign new_entry.bp_value = s_tdata[2*W-1:W];
	assign tail_in = scan_en ? cell_out[0] : new_entry;
	assign cur = cell_out[0];

	for (genvar j = 0; j < D; j++) begin : g_cell
		if (j == D - 1) begin : g_tail
			pli_cell u_cell (.clk(clk), .shift(shift_en), .din(tail_in), .dout(cell_out[j]));
		end else begin : g_body
			pli_cell u_cell (.clk(clk), .shift(shift_en), .din(cell_out[j+1]),
				.dout(cell_out[j]));
		end
	end

	always_comb begin
		width_c = {it1_q[W-1], it1_q} - {it0_q[W-1], it0_q};
		dv_c = {iv1_q[W-1], iv1_q} - {iv0_q[W-1], iv0_q};
		dt_c = {qt_q[W-1], qt_q} - {it0_q[W-1], it0_q};
		width_bad = width_c[W] || (width_c == '0);
		mag_c = dv_c[W] ? W'(-dv_c) : dv_c[W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pli_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == pli_pkg::OP_QUERY) begin
					state_d = (count_q == '0) ? pli_pkg::ST_DONE : pli_pkg::ST_SCAN;
				end
			end
			pli_pkg::ST_SCAN: begin
				if (k_q == pli_pkg::IDX_W'(D - 1)) begin
					state_d = pli_pkg::ST_DECIDE;
				end
			end
			pli_pkg::ST_DECIDE: begin
				if (first_le_q || last_ge_q || !found_q || width_bad) begin
					state_d = pli_pkg::ST_DONE;
				end else begin
					state_d = pli_pkg::ST_MUL;
				end
			end
			pli_pkg::ST_MUL: begin
				state_d = pli_pkg::ST_DIV;
			end
			pli_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = pli_pkg::ST_DONE;
				end
			end
			pli_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pli_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pli_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		scan_en = 1'b0;
		div_start = 1'b0;
		case (state_q)
			pli_pkg::ST_IDLE: s_tready = 1'b1;
			pli_pkg::ST_SCAN: scan_en = 1'b1;
			pli_pkg::ST_MUL: div_start = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pli_pkg::ST_IDLE;
			count_q <= '0;
			k_q <= '0;
			found_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && s_tuser == pli_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (append_en) begin
				count_q <= count_q + 1'b1;
			end
			if (in_acc) begin
				k_q <= '0;
				found_q <= 1'b0;
			end else if (scan_en) begin
				k_q <= k_q + 1'b1;
				if (k_q > start_q && !found_q && prev_q.bp_time <= qt_q
					&& qt_q <= cur.bp_time) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == pli_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign prod = mag_q * dt_q;

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (width_q),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (in_acc && s_tuser == pli_pkg::OP_QUERY) begin
			qt_q <= s_tdata[W-1:0];
			start_q <= pli_pkg::IDX_W'(pli_pkg::CNT_W'(D) - count_q);
			res_q <= '0;
			empty_q <= (count_q == '0);
		end
		if (scan_en) begin
			prev_q <= cur;
			if (k_q == start_q) begin
				first_le_q <= (qt_q <= cur.bp_time);
				v_first_q <= cur.bp_value;
			end else if (k_q > start_q && !found_q && prev_q.bp_time <= qt_q
				&& qt_q <= cur.bp_time) begin
				it0_q <= prev_q.bp_time;
				iv0_q <= prev_q.bp_value;
				it1_q <= cur.bp_time;
				iv1_q <= cur.bp_value;
			end
			if (k_q == pli_pkg::IDX_W'(D - 1)) begin
				last_ge_q <= (qt_q >= cur.bp_time);
				v_last_q <= cur.bp_value;
			end
		end
		if (state_q == pli_pkg::ST_DECIDE) begin
			width_q <= width_c[W-1:0];
			dt_q <= dt_c[W-1:0];
			mag_q <= mag_c;
			neg_q <= dv_c[W];
			if (first_le_q) begin
				res_q <= v_first_q;
			end else if (last_ge_q) begin
				res_q <= v_last_q;
			end else if (!found_q) begin
				res_q <= '0;
			end else begin
				res_q <= iv0_q;
			end
		end
		if (state_q == pli_pkg::ST_DIV && div_done) begin
			res_q <= neg_q ? iv0_q - $signed(quo) : iv0_q + $signed(quo);
		end
		if (state_q == pli_pkg::ST_DONE && out_free) begin
			m_tdata_q <= res_q;
			m_tuser_q <= empty_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 600;
	localparam int STALL_CYCLES = 1500;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = pli_pkg::TABLE_DEPTH + 100;

	typedef struct packed {
		logic [31:0] value;
		logic        empty;
	} interp_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // time_in [31:0], value_in [63:32]
	logic [1:0]  s_tuser;   // opcode [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // value_out [31:0]
	logic [0:0]  m_tuser;   // table_empty [0]

	logic signed [31:0] tbl_time [pli_pkg::TABLE_DEPTH];
	logic signed [31:0] tbl_value [pli_pkg::TABLE_DEPTH];
	int                 tbl_count = 0;
	interp_result_t     pending_results [$];

	int error_count = 0;
	int items_sent = 0;
	int rx_hold_len = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	piecewise_linear_interpolator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic interp_result_t interp_value(input logic signed [31:0] query_time);
		interp_result_t r;
		longint t, t0, t1, v0, v1, dv, width, res;
		bit [63:0] mag, prod, quo;
		bit found;
		r.value = '0;
		r.empty = 1'b0;
		found = 1'b0;
		if (tbl_count == 0) begin
			r.empty = 1'b1;
			return r;
		end
		t = query_time;
		t0 = tbl_time[0];
		t1 = tbl_time[tbl_count-1];
		if (t <= t0) begin
			r.value = tbl_value[0];
		end else if (t >= t1) begin
			r.value = tbl_value[tbl_count-1];
		end else begin
			for (int i = 0; i + 1 < tbl_count && !found; i++) begin
				t0 = tbl_time[i];
				t1 = tbl_time[i+1];
				if (t >= t0 && t <= t1) begin
					found = 1'b1;
					v0 = tbl_value[i];
					v1 = tbl_value[i+1];
					width = t1 - t0;
					if (width <= 0) begin
						res = v0;
					end else begin
						dv = v1 - v0;
						mag = (dv < 0) ? -dv : dv;
						prod = mag * 64'(t - t0);
						quo = prod / 64'(width);
						res = (dv < 0) ? v0 - longint'(quo) : v0 + longint'(quo);
					end
					r.value = res[31:0];
				end
			end
		end
		return r;
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [31:0] t, input logic [31:0] v);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {v, t};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		case (op)
			pli_pkg::OP_CLEAR: tbl_count = 0;
			pli_pkg::OP_APPEND: begin
				if (tbl_count < pli_pkg::TABLE_DEPTH) begin
					tbl_time[tbl_count] = t;
					tbl_value[tbl_count] = v;
					tbl_count++;
				end
			end
			pli_pkg::OP_QUERY: pending_results.push_back(interp_value(t));
			default: ;
		endcase
	endtask

	task automatic send_random_query();
		logic signed [31:0] r32;
		bit [63:0] r64;
		longint t, t0, t1;
		int i;
		r32 = $urandom;
		t = r32;
		if (tbl_count >= 2 && $urandom_range(0, 9) < 7) begin
			i = $urandom_range(0, tbl_count - 2);
			t0 = tbl_time[i];
			t1 = tbl_time[i+1];
			r64 = {$urandom, $urandom};
			if (t1 > t0) t = t0 + longint'(r64 % 64'(t1 - t0 + 1));
			else t = t0;
		end else if (tbl_count >= 1 && $urandom_range(0, 2) == 0) begin
			t = tbl_time[$urandom_range(0, tbl_count - 1)];
		end
		send_word(pli_pkg::OP_QUERY, t[31:0], $urandom);
	endtask

	task automatic test_empty_table();
		send_word(pli_pkg::OP_QUERY, 32'h0000_0000, 32'h0000_0000);
		send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(pli_pkg::OP_QUERY, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(pli_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(pli_pkg::OP_APPEND, 32'h0001_0000, 32'h7FFF_FFFF);
		send_word(pli_pkg::OP_QUERY, 32'h0000_FFFF, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h0001_0000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h0);
	endtask

	task automatic test_interpolation();
		send_word(pli_pkg::OP_CLEAR, 32'h0, 32'h0);
		send_word(pli_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000);
		send_word(pli_pkg::OP_APPEND, 32'h0000_0000, 32'h7FFF_FFFF);
		send_word(pli_pkg::OP_APPEND, 32'h0003_0000, 32'h0001_0000);
		send_word(pli_pkg::OP_APPEND, 32'h0003_0000, 32'h0005_0000);
		send_word(pli_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'hFFFF_0000);
		send_word(pli_pkg::OP_QUERY, 32'h8000_0000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h8000_0001, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'hC000_0000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h0001_8000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h0003_0000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h4000_0000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h0);
	endtask

	task automatic test_out_of_order();
		send_word(pli_pkg::OP_CLEAR, 32'h0, 32'h0);
		send_word(pli_pkg::OP_APPEND, 32'h0001_0000, 32'h0010_0000);
		send_word(pli_pkg::OP_APPEND, 32'h0005_0000, 32'hFFF0_0000);
		send_word(pli_pkg::OP_APPEND, 32'h0002_0000, 32'h0003_0000);
		send_word(pli_pkg::OP_APPEND, 32'h0006_0000, 32'h0000_8000);
		send_word(pli_pkg::OP_QUERY, 32'h0003_0000, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h0005_5000, 32'h0);
	endtask

	// The word after the last slot is dropped, so the top clamp must still return slot 255.
	task automatic test_full_table();
		send_word(pli_pkg::OP_CLEAR, 32'h0, 32'h0);
		for (int i = 0; i < pli_pkg::TABLE_DEPTH; i++)
			send_word(pli_pkg::OP_APPEND, 32'((i - 128) * 65536), $urandom);
		send_word(pli_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h1234_5678);
		send_word(pli_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h0);
		send_word(pli_pkg::OP_QUERY, 32'h007F_0000, 32'h0);
		repeat (3) send_random_query();
	endtask

	task automatic test_output_stall();
		send_word(pli_pkg::OP_CLEAR, 32'h0, 32'h0);
		send_word(pli_pkg::OP_APPEND, 32'hFFF0_0000, $urandom);
		send_word(pli_pkg::OP_APPEND, 32'h0000_0000, $urandom);
		send_word(pli_pkg::OP_APPEND, 32'h0010_0000, $urandom);
		rx_hold_len = STALL_CYCLES;
		repeat (6) send_random_query();
	endtask

	task automatic send_noise_burst();
		logic [1:0] op;
		repeat ($urandom_range(1, 6)) begin
			op = 2'($urandom_range(0, 3));
			send_word(op, $urandom, $urandom);
		end
	endtask

	task automatic build_random_table();
		int n, nq;
		longint cur;
		logic signed [31:0] r32;
		bit [31:0] incr;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(2, 6);
		nq = $urandom_range(2, 8);
		send_word(pli_pkg::OP_CLEAR, $urandom, $urandom);
		r32 = $urandom;
		cur = r32;
		if ($urandom_range(0, 1) == 1) cur = cur >>> $urandom_range(1, 31);
		for (int k = 0; k < n; k++) begin
			send_word(pli_pkg::OP_APPEND, cur[31:0], $urandom);
			incr = $urandom >> $urandom_range(2, 32);
			cur += incr;
			if (cur > 64'sd2147483647) cur = 64'sd2147483647;
		end
		repeat (nq) send_random_query();
	endtask

	task automatic test_random_tables();
		while (items_sent < RANDOM_ITEMS) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0) send_noise_burst();
			else build_random_table();
		end
	endtask

	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_len > 0) begin
				gap = rx_hold_len;
				rx_hold_len = 0;
			end else begin
				gap = rx_idle_on ? $urandom_range(0, 3) : 0;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin : result_check
		interp_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected word: value_out %h table_empty %b", m_tdata, m_tuser[0]);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.value) begin
						$error("value_out: expected %h, got %h", want.value, m_tdata);
						error_count++;
					end
					if (m_tuser[0] !== want.empty) begin
						$error("table_empty: expected %b, got %b", want.empty, m_tuser[0]);
						error_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = pli_pkg::OP_CLEAR;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_interpolation();
		test_out_of_order();
		test_full_table();
		test_output_stall();
		test_random_tables();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
